/* hdl/lgpc_pkg.sv */
// Package for the linear gradient pixel color block.
// Holds widths, stage positions, register and region codes and payload types.
// No dependencies; every other file of the block imports it.
package lgpc_pkg;

  localparam int CW    = 16;         // coordinate width
  localparam int DW    = CW + 1;     // coordinate difference width
  localparam int PW    = 2 * CW;     // product magnitude and quotient width
  localparam int LW    = PW + 1;     // ramp length and offset width
  localparam int SW    = PW + 4;     // signed ramp position width
  localparam int CH    = 8;          // color channel width
  localparam int NCH   = 3;          // channels per color
  localparam int CLR_W = NCH * CH;
  localparam int QB    = CH;         // quotient bits of the blend division
  localparam int BW    = LW + CH;    // blend dividend width
  localparam int IW    = 3;          // register index width
  localparam int DATA_W = CLR_W;     // configuration write data width

  // Pipeline stage positions.
  localparam int S_IN   = 0;
  localparam int S_MUL  = S_IN + 1;
  localparam int S_DIV  = S_MUL + 1;
  localparam int S_LEN  = S_DIV + PW;
  localparam int S_LO   = S_LEN + 1;
  localparam int S_POS  = S_LO + 1;
  localparam int S_OFF  = S_POS + 1;
  localparam int S_PROD = S_OFF + 1;
  localparam int S_BL   = S_PROD + 1;
  localparam int S_OUT  = S_BL + QB;
  localparam int NSTG   = S_OUT + 1;

  // Register indexes.
  localparam logic [IW-1:0] REG_A_X   = 3'd0;
  localparam logic [IW-1:0] REG_A_Y   = 3'd1;
  localparam logic [IW-1:0] REG_B_X   = 3'd2;
  localparam logic [IW-1:0] REG_B_Y   = 3'd3;
  localparam logic [IW-1:0] REG_START = 3'd4;
  localparam logic [IW-1:0] REG_END   = 3'd5;

  // Where a pixel sits relative to the ramp.
  localparam logic [1:0] RGN_BEFORE = 2'd0;
  localparam logic [1:0] RGN_INSIDE = 2'd1;
  localparam logic [1:0] RGN_AFTER  = 2'd2;

  typedef struct packed {
    logic signed [CW-1:0] pixel_x;
    logic signed [CW-1:0] pixel_y;
  } pixel_t;

  typedef struct packed {
    logic [CH-1:0] red;
    logic [CH-1:0] green;
    logic [CH-1:0] blue;
  } color_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [DW-1:0] pos_v;
    logic                 rneg;
  } div_side_t;

  typedef struct packed {
    logic [NCH-1:0] neg;
    logic [1:0]     region;
  } bl_side_t;

endpackage

/* hdl/lgpc_div.sv */
// Pipelined restoring divider, one quotient bit per stage, two numerators
// sharing one divisor. Depends on lgpc_pkg.
module lgpc_div (
  input  logic                  clk,
  input  logic [lgpc_pkg::PW-1:0] en,
  input  logic [lgpc_pkg::CW-1:0] den,
  input  logic [lgpc_pkg::PW-1:0] num_a,
  input  logic [lgpc_pkg::PW-1:0] num_b,
  output logic [lgpc_pkg::PW-1:0] quot_a,
  output logic [lgpc_pkg::PW-1:0] quot_b
);
  import lgpc_pkg::*;

  logic [CW-1:0] rem_a [PW];
  logic [CW-1:0] rem_b [PW];
  logic [PW-1:0] n_a   [PW];
  logic [PW-1:0] n_b   [PW];
  logic [PW-1:0] q_a   [PW];
  logic [PW-1:0] q_b   [PW];

  for (genvar j = 0; j < PW; j++) begin : g_stage
    logic [CW-1:0] ra_in, rb_in;
    logic [PW-1:0] na_in, nb_in, qa_in, qb_in;
    logic [CW:0]   sh_a, sh_b, df_a, df_b;
    logic          ge_a, ge_b;

    if (j == 0) begin : g_first
      assign ra_in = '0;
      assign rb_in = '0;
      assign na_in = num_a;
      assign nb_in = num_b;
      assign qa_in = '0;
      assign qb_in = '0;
    end else begin : g_next
      assign ra_in = rem_a[j-1];
      assign rb_in = rem_b[j-1];
      assign na_in = n_a[j-1];
      assign nb_in = n_b[j-1];
      assign qa_in = q_a[j-1];
      assign qb_in = q_b[j-1];
    end

    always_comb begin
      sh_a = {ra_in, na_in[PW-1]};
      sh_b = {rb_in, nb_in[PW-1]};
      ge_a = sh_a >= {1'b0, den};
      ge_b = sh_b >= {1'b0, den};
      df_a = sh_a - {1'b0, den};
      df_b = sh_b - {1'b0, den};
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem_a[j] <= ge_a ? df_a[CW-1:0] : sh_a[CW-1:0];
        rem_b[j] <= ge_b ? df_b[CW-1:0] : sh_b[CW-1:0];
        n_a[j]   <= {na_in[PW-2:0], 1'b0};
        n_b[j]   <= {nb_in[PW-2:0], 1'b0};
        q_a[j]   <= {qa_in[PW-2:0], ge_a};
        q_b[j]   <= {qb_in[PW-2:0], ge_b};
      end
    end
  end

  assign quot_a = q_a[PW-1];
  assign quot_b = q_b[PW-1];

endmodule

/* hdl/lgpc_blend.sv */
// Pipelined blend division: for each channel, product over ramp length,
// one quotient bit per stage. Depends on lgpc_pkg.
module lgpc_blend (
  input  logic                    clk,
  input  logic [lgpc_pkg::QB-1:0] en,
  input  logic [lgpc_pkg::LW-1:0] len,
  input  logic [lgpc_pkg::BW-1:0] prod [lgpc_pkg::NCH],
  output logic [lgpc_pkg::QB-1:0] quot [lgpc_pkg::NCH]
);
  import lgpc_pkg::*;

  logic [BW-1:0] rem [QB][NCH];
  logic [QB-1:0] q   [QB][NCH];
  logic [LW-1:0] lq  [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [BW-1:0] r_in  [NCH];
    logic [QB-1:0] q_in  [NCH];
    logic [LW-1:0] l_in;
    logic [BW-1:0] trial;
    logic [BW-1:0] r_out [NCH];
    logic [NCH-1:0] ge;

    if (k == 0) begin : g_first
      assign l_in = len;
      for (genvar c = 0; c < NCH; c++) begin : g_ch
        assign r_in[c] = prod[c];
        assign q_in[c] = '0;
      end
    end else begin : g_next
      assign l_in = lq[k-1];
      for (genvar c = 0; c < NCH; c++) begin : g_ch
        assign r_in[c] = rem[k-1][c];
        assign q_in[c] = q[k-1][c];
      end
    end

    always_comb begin
      trial = BW'(l_in) << (QB - 1 - k);
      for (int c = 0; c < NCH; c++) begin
        ge[c]    = r_in[c] >= trial;
        r_out[c] = ge[c] ? r_in[c] - trial : r_in[c];
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        lq[k] <= l_in;
        for (int c = 0; c < NCH; c++) begin
          rem[k][c] <= r_out[c];
          q[k][c]   <= {q_in[c][QB-2:0], ge[c]};
        end
      end
    end
  end

  for (genvar c = 0; c < NCH; c++) begin : g_out
    assign quot[c] = q[QB-1][c];
  end

endmodule

/* hdl/linear_gradient_pixel_color.sv */
// Linear gradient pixel color, top level.
// Depends on lgpc_pkg, lgpc_div and lgpc_blend.
//
// Usage: the two origin points and the start and end colors are written over
// the configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) while
// no pixel is in flight; cfg_ready is always high. Each transaction on the
// input channel (in_valid, in_stall, in_data) carries one pixel coordinate and
// yields exactly one transaction on the output channel (out_valid, out_stall,
// out_data) holding the red, green and blue gradient channels.
// Each pixel passes through the input, multiply, divider, length, ramp start,
// position, offset, product, blend division and output register stages. One
// pixel can enter every cycle while the pipeline does not stall; the depth is
// set by the 32-stage restoring divider that produces the ramp start and
// length (one quotient bit per stage) and the 8-stage divider that scales
// each color difference.
// Reset clears the configuration registers to zero and empties the pipeline.
// When the receiver stalls, full stages hold, but any stage that is empty
// still takes data from the stage behind it, so in_stall rises only when
// every stage up to the first one is full and cannot move.
module linear_gradient_pixel_color (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lgpc_pkg::IW-1:0]     cfg_index,
  input  logic [lgpc_pkg::DATA_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  lgpc_pkg::pixel_t            in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output lgpc_pkg::color_t            out_data
);
  import lgpc_pkg::*;

  // Configuration registers.
  logic signed [CW-1:0] ax, ay, bx, by;
  logic [CLR_W-1:0]     start_color, end_color;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ax          <= '0;
      ay          <= '0;
      bx          <= '0;
      by          <= '0;
      start_color <= '0;
      end_color   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_A_X:   ax <= cfg_data[CW-1:0];
        REG_A_Y:   ay <= cfg_data[CW-1:0];
        REG_B_X:   bx <= cfg_data[CW-1:0];
        REG_B_Y:   by <= cfg_data[CW-1:0];
        REG_START: start_color <= cfg_data[CLR_W-1:0];
        REG_END:   end_color <= cfg_data[CLR_W-1:0];
        default: ;
      endcase
    end
  end

  // Values that follow from configuration alone. The user holds them constant
  // while pixels are in flight (not enforced), so every stage reads them directly.
  logic signed [DW-1:0] dx, dy, dxn, dyn;
  logic [CW-1:0]        ad, ady;
  logic signed [CW-1:0] lo_v;
  logic                 vert, fwd;

  always_comb begin
    dx   = DW'(bx) - DW'(ax);
    dy   = DW'(by) - DW'(ay);
    dxn  = -dx;
    dyn  = -dy;
    ad   = dx[DW-1] ? dxn[CW-1:0] : dx[CW-1:0];
    ady  = dy[DW-1] ? dyn[CW-1:0] : dy[CW-1:0];
    lo_v = (ay < by) ? ay : by;
    vert = (dx == '0);
    // The gradient runs forward when it goes from start toward end as the
    // ramp position grows.
    fwd  = vert ? (dy > 0) : (dx > 0);
  end

  // Stage valid bits and advance enables. A stage loads when it is empty or
  // when the stage after it loads; the last stage loads when it is empty or
  // the receiver takes its transaction. A stage that does not load keeps its
  // item and its valid bit.
  logic [NSTG-1:0] v, v_next, en;

  always_comb begin
    en[NSTG-1] = !v[NSTG-1] || !out_stall;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
    v_next[0] = en[0] ? in_valid : v[0];
    for (int i = 1; i < NSTG; i++) begin
      v_next[i] = en[i] ? v[i-1] : v[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= v_next;
    end
  end

  assign in_stall  = !en[S_IN];
  assign out_valid = v[NSTG-1];

  // Input stage: row offset from origin a and the vertical ramp index.
  logic signed [CW-1:0] x0;
  logic signed [DW-1:0] ayy0, posv0;

  always_ff @(posedge clk) begin
    if (en[S_IN]) begin
      x0    <= in_data.pixel_x;
      ayy0  <= DW'(ay) - DW'(in_data.pixel_y);
      posv0 <= DW'(in_data.pixel_y) - DW'(lo_v);
    end
  end

  // Multiply stage: dy squared for the length, dy times the row offset for
  // the ramp start. Both go to the divider as magnitudes.
  logic signed [2*DW-1:0] prs, prn;
  logic [PW-1:0]          sq1, prm1;
  div_side_t              side1;

  always_comb begin
    prs = dy * ayy0;
    prn = -prs;
  end

  always_ff @(posedge clk) begin
    if (en[S_MUL]) begin
      sq1         <= PW'(ady) * PW'(ady);
      prm1        <= prs[2*DW-1] ? prn[PW-1:0] : prs[PW-1:0];
      side1.x     <= x0;
      side1.pos_v <= posv0;
      side1.rneg  <= prs[2*DW-1] ^ dx[DW-1];
    end
  end

  // Divider stages, with the pixel's side data carried alongside.
  logic [PW-1:0] qsq, qrow;
  div_side_t     dside [PW];

  lgpc_div u_div (
    .clk    (clk),
    .en     (en[S_DIV +: PW]),
    .den    (ad),
    .num_a  (sq1),
    .num_b  (prm1),
    .quot_a (qsq),
    .quot_b (qrow)
  );

  always_ff @(posedge clk) begin
    for (int j = 0; j < PW; j++) begin
      if (en[S_DIV + j]) begin
        dside[j] <= (j == 0) ? side1 : dside[(j == 0) ? 0 : j - 1];
      end
    end
  end

  // Length stage: dy*dy/dx has the sign of dx, so the length magnitude is
  // |dx| plus the unsigned quotient. The ramp start before the left shift
  // is origin a's x plus the signed row quotient.
  logic [LW-1:0]        len2;
  logic signed [SW-1:0] lo0, rowq;
  logic signed [CW-1:0] x2;
  logic signed [DW-1:0] posv2;

  assign rowq = dside[PW-1].rneg ? -SW'(qrow) : SW'(qrow);

  always_ff @(posedge clk) begin
    if (en[S_LEN]) begin
      len2  <= LW'(ad) + LW'(qsq);
      lo0   <= SW'(ax) + rowq;
      x2    <= dside[PW-1].x;
      posv2 <= dside[PW-1].pos_v;
    end
  end

  // Ramp start stage: a gradient running toward smaller x starts one length
  // further left.
  logic [LW-1:0]        len3;
  logic signed [SW-1:0] lo3;
  logic signed [CW-1:0] x3;
  logic signed [DW-1:0] posv3;

  always_ff @(posedge clk) begin
    if (en[S_LO]) begin
      len3  <= len2;
      lo3   <= dx[DW-1] ? lo0 - SW'(len2) : lo0;
      x3    <= x2;
      posv3 <= posv2;
    end
  end

  // Position stage: vertical and slanted cases merge into one ramp index
  // and one length.
  logic [LW-1:0]        len4;
  logic signed [SW-1:0] pos4;

  always_ff @(posedge clk) begin
    if (en[S_POS]) begin
      len4 <= vert ? LW'(ady) : len3;
      pos4 <= vert ? SW'(posv3) : SW'(x3) - lo3;
    end
  end

  // Offset stage: classify against the ramp and mirror the index for a
  // gradient that runs backward.
  logic [LW-1:0] len5, off5;
  logic [1:0]    rgn5;

  always_ff @(posedge clk) begin
    if (en[S_OFF]) begin
      len5 <= len4;
      off5 <= fwd ? pos4[LW-1:0] : len4 - LW'(1) - pos4[LW-1:0];
      if (pos4 < 0) begin
        rgn5 <= RGN_BEFORE;
      end else if (pos4 >= $signed(SW'(len4))) begin
        rgn5 <= RGN_AFTER;
      end else begin
        rgn5 <= RGN_INSIDE;
      end
    end
  end

  // Product stage: color difference magnitude times offset, per channel.
  logic [BW-1:0]  prod6 [NCH];
  logic [LW-1:0]  len6;
  bl_side_t       side6;

  always_ff @(posedge clk) begin
    if (en[S_PROD]) begin
      len6         <= len5;
      side6.region <= rgn5;
      for (int c = 0; c < NCH; c++) begin
        side6.neg[c] <= end_color[CH*c +: CH] < start_color[CH*c +: CH];
        prod6[c] <= BW'((end_color[CH*c +: CH] < start_color[CH*c +: CH]) ?
                        start_color[CH*c +: CH] - end_color[CH*c +: CH] :
                        end_color[CH*c +: CH] - start_color[CH*c +: CH]) * BW'(off5);
      end
    end
  end

  // Blend division stages.
  logic [QB-1:0] bq [NCH];
  bl_side_t      bside [QB];

  lgpc_blend u_blend (
    .clk  (clk),
    .en   (en[S_BL +: QB]),
    .len  (len6),
    .prod (prod6),
    .quot (bq)
  );

  always_ff @(posedge clk) begin
    for (int k = 0; k < QB; k++) begin
      if (en[S_BL + k]) begin
        bside[k] <= (k == 0) ? side6 : bside[(k == 0) ? 0 : k - 1];
      end
    end
  end

  // Output register: solid colors outside the ramp, start plus the signed
  // quotient inside, wrapped to eight bits.
  logic [CLR_W-1:0] color_next;

  always_comb begin
    color_next = start_color;
    case (bside[QB-1].region)
      RGN_BEFORE: color_next = fwd ? start_color : end_color;
      RGN_AFTER:  color_next = fwd ? end_color : start_color;
      default: begin
        for (int c = 0; c < NCH; c++) begin
          color_next[CH*c +: CH] = bside[QB-1].neg[c] ?
                                   start_color[CH*c +: CH] - bq[c] :
                                   start_color[CH*c +: CH] + bq[c];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[S_OUT]) begin
      out_data.red   <= color_next[0 +: CH];
      out_data.green <= color_next[CH +: CH];
      out_data.blue  <= color_next[2*CH +: CH];
    end
  end

endmodule

/* dv/tb.sv */
// Self-checking testbench for linear_gradient_pixel_color.
// Depends on lgpc_pkg and the block's RTL; drives pixels, predicts every
// gradient color with an exact integer model of its own and checks the results.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lgpc_pkg::*;

  localparam int LATENCY     = 47;
  localparam int SETTLE      = LATENCY + 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETS        = 6;    // register settings per idling phase
  localparam int PER_SET     = 97;   // random pixels per register setting
  localparam int NREG        = 6;
  // The index just past the last register; writes there must do nothing.
  localparam logic [IW-1:0] REG_UNUSED = 3'd6;

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [IW-1:0]      cfg_index;
  logic [DATA_W-1:0]  cfg_data;
  logic               in_valid;
  logic               in_stall;
  pixel_t             in_data;
  logic               out_valid;
  logic               out_stall;
  color_t             out_data;

  linear_gradient_pixel_color uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Shadow copy of the block's registers, as the predictor sees them.
  logic signed [CW-1:0] org_ax, org_ay, org_bx, org_by;
  logic [CLR_W-1:0]     color_start, color_end;

  color_t pending_colors[$];
  int     fail_count;
  int     cycle_count;
  int     send_idle_pct;
  int     recv_idle_pct;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Unpack a register-format color: red is the low byte, blue the high byte.
  function automatic color_t unpack_color(logic [CLR_W-1:0] c);
    color_t r;
    r.red   = c[7:0];
    r.green = c[15:8];
    r.blue  = c[23:16];
    return r;
  endfunction

  function automatic color_t ramp_color(longint off, longint len);
    longint c1, c2, v;
    logic [CLR_W-1:0] mix;
    for (int k = 0; k < NCH; k++) begin
      c1 = color_start[8*k +: 8];
      c2 = color_end[8*k +: 8];
      v  = c1 + ((c2 - c1) * off) / len;
      mix[8*k +: 8] = v[7:0];
    end
    return unpack_color(mix);
  endfunction

  // Exact integer gradient: SystemVerilog division on longint truncates toward
  // zero, which matches the rounding the block is specified with.
  function automatic color_t gradient_color(pixel_t p);
    longint ax, ay, bx, by, x, y, dx, dy, lo, hi, len, idx;
    ax = org_ax; ay = org_ay; bx = org_bx; by = org_by;
    x  = p.pixel_x;
    y  = p.pixel_y;
    dx = bx - ax;
    dy = by - ay;
    if (dx == 0) begin
      // Vertical gradient; coincident origins fall out as an empty ramp.
      lo  = (ay < by) ? ay : by;
      hi  = (ay < by) ? by : ay;
      len = hi - lo;
      if (y < lo) return unpack_color(by > ay ? color_start : color_end);
      if (y >= hi) return unpack_color(by > ay ? color_end : color_start);
      idx = y - lo;
      return ramp_color(dy > 0 ? idx : len - 1 - idx, len);
    end
    len = dx + (dy * dy) / dx;
    if (len < 0) len = -len;
    lo = ax + (dy * (ay - y)) / dx;
    if (dx < 0) lo -= len;
    hi = lo + len;
    if (x < lo) return unpack_color(dx > 0 ? color_start : color_end);
    if (x >= hi) return unpack_color(dx > 0 ? color_end : color_start);
    idx = x - lo;
    return ramp_color(dx > 0 ? idx : len - 1 - idx, len);
  endfunction

  // Scoreboard: every accepted pixel queues its color, and every output
  // transaction must match the oldest one field by field.
  always @(posedge clk) begin
    color_t want;
    if (!rst) begin
      if (in_valid && !in_stall) pending_colors.push_back(gradient_color(in_data));
      if (out_valid && !out_stall) begin
        if (pending_colors.size() == 0) begin
          $display("%0t: unexpected output transaction, actual r=%h g=%h b=%h",
                   $time, out_data.red, out_data.green, out_data.blue);
          fail_count++;
        end else begin
          want = pending_colors.pop_front();
          if (want.red !== out_data.red || want.green !== out_data.green ||
              want.blue !== out_data.blue) begin
            $display("%0t: color mismatch, expected r=%h g=%h b=%h, actual r=%h g=%h b=%h",
                     $time, want.red, want.green, want.blue,
                     out_data.red, out_data.green, out_data.blue);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // The receiver stalls at random; the rate is set per idling phase.
  always @(negedge clk) begin
    out_stall = !rst && ($urandom_range(99) < recv_idle_pct);
  end

  task automatic write_reg(logic [IW-1:0] idx, logic [DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_A_X:   org_ax      = val[CW-1:0];
      REG_A_Y:   org_ay      = val[CW-1:0];
      REG_B_X:   org_bx      = val[CW-1:0];
      REG_B_Y:   org_by      = val[CW-1:0];
      REG_START: color_start = val;
      REG_END:   color_end   = val;
      default: ;
    endcase
  endtask

  // Writes all six registers plus one to a random unused index, then drops valid.
  task automatic load_setting(logic [DATA_W-1:0] regs[NREG]);
    write_reg(REG_A_X, regs[0]);
    write_reg(REG_A_Y, regs[1]);
    write_reg(REG_B_X, regs[2]);
    write_reg(REG_B_Y, regs[3]);
    write_reg(REG_START, regs[4]);
    write_reg(REG_END, regs[5]);
    write_reg(IW'(REG_UNUSED + $urandom_range(1)), DATA_W'($urandom));
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // The sender holds off until every queued color has come back.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_pixel(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid        = 1'b1;
    in_data.pixel_x = x;
    in_data.pixel_y = y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [CW-1:0] pick_coord(bit extreme);
    case ($urandom_range(3))
      0: return extreme ? 16'h8000 : 16'($signed($urandom_range(120)) - 60);
      1: return extreme ? 16'h7fff : 16'($signed($urandom_range(120)) - 60);
      2: return extreme ? 16'h0000 : 16'($signed($urandom_range(120)) - 60);
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic logic [CLR_W-1:0] pick_color();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      default: return CLR_W'($urandom);
    endcase
  endfunction

  // Random origins: mostly small so the ramps land where pixels fall, with
  // vertical and coincident layouts mixed in. Coordinate registers also get
  // random upper data bits, which the block must ignore.
  task automatic random_setting(bit extreme);
    logic [DATA_W-1:0] regs[NREG];
    for (int i = 0; i < 4; i++) regs[i] = {8'($urandom), pick_coord(extreme)};
    case ($urandom_range(9))
      0, 1: regs[2][CW-1:0] = regs[0][CW-1:0];
      2: begin
        regs[2][CW-1:0] = regs[0][CW-1:0];
        regs[3][CW-1:0] = regs[1][CW-1:0];
      end
      default: ;
    endcase
    regs[4] = pick_color();
    regs[5] = pick_color();
    load_setting(regs);
  endtask

  task automatic random_pixel();
    longint cx, cy, span;
    if ($urandom_range(99) < 20) begin
      send_pixel(CW'($urandom), CW'($urandom));
    end else begin
      cx   = (longint'(org_ax) + longint'(org_bx)) / 2;
      cy   = (longint'(org_ay) + longint'(org_by)) / 2;
      span = (org_bx > org_ax ? longint'(org_bx) - org_ax : longint'(org_ax) - org_bx)
           + (org_by > org_ay ? longint'(org_by) - org_ay : longint'(org_ay) - org_by);
      span = (span > 30000 ? 30000 : span) + 16;
      send_pixel(16'(cx + $signed($urandom_range(2 * span)) - span),
                 16'(cy + $signed($urandom_range(2 * span)) - span));
    end
  endtask

  typedef struct {
    int                 setting;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    bit                 typed;    // the expected color below is checked too
    logic [CLR_W-1:0]   color;
  } pixel_row_t;

  // Register settings of the directed part. Setting zero is the reset state.
  logic [DATA_W-1:0] dir_settings[6][NREG] = '{
    '{24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0},
    // vertical, running downward
    '{24'h0, 24'hfff6, 24'h0, 24'h000a, 24'h000000, 24'hffffff},
    // vertical, running upward
    '{24'h5, 24'h000a, 24'h5, 24'hfff6, 24'h123456, 24'habcdef},
    // coincident origins
    '{24'h64, 24'hfffb, 24'h64, 24'hfffb, 24'h0000ff, 24'hff0000},
    // slanted, full coordinate range
    '{24'h8000, 24'h8000, 24'h7fff, 24'h7fff, 24'hffffff, 24'h000000},
    // slanted with the second origin to the left
    '{24'h7fff, 24'h0, 24'h8000, 24'h64, 24'h00ff00, 24'h0000ff}
  };

  pixel_row_t dir_rows[] = '{
    '{0, 16'sh0000, 16'sh0000, 1, 24'h000000},
    '{0, -16'sd32768, -16'sd32768, 1, 24'h000000},
    '{1, 16'sd0, -16'sd11, 1, 24'h000000},
    '{1, 16'sd0, 16'sd10, 1, 24'hffffff},
    '{1, 16'sd3, 16'sd0, 0, 24'h0},
    '{1, 16'sd3, -16'sd10, 0, 24'h0},
    '{1, 16'sd3, 16'sd9, 0, 24'h0},
    '{2, 16'sd0, -16'sd32768, 1, 24'habcdef},
    '{2, 16'sd0, 16'sd32767, 1, 24'h123456},
    '{2, 16'sd0, 16'sd9, 0, 24'h0},
    '{2, 16'sd0, -16'sd10, 0, 24'h0},
    '{3, 16'sd100, -16'sd6, 1, 24'hff0000},
    '{3, 16'sd100, -16'sd5, 1, 24'h0000ff},
    '{4, -16'sd32768, -16'sd32768, 0, 24'h0},
    '{4, 16'sd32767, 16'sd32767, 0, 24'h0},
    '{4, -16'sd32768, 16'sd32767, 0, 24'h0},
    '{4, 16'sd32767, -16'sd32768, 0, 24'h0},
    '{4, 16'sd0, 16'sd0, 0, 24'h0},
    '{5, 16'sd0, 16'sd0, 0, 24'h0},
    '{5, -16'sd32768, 16'sd50, 0, 24'h0},
    '{5, 16'sd32767, 16'sd100, 0, 24'h0},
    '{5, 16'sd12345, -16'sd200, 0, 24'h0}
  };

  initial begin
    int     current;
    color_t typed_color;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    org_ax = '0; org_ay = '0; org_bx = '0; org_by = '0;
    color_start = '0;
    color_end   = '0;
    fail_count  = 0;
    cycle_count = 0;
    send_idle_pct = 24;
    recv_idle_pct = 79;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed rows. A typed-in color must also agree with the predictor,
    // so a slip in either shows up as a failure here.
    current = 0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].setting != current) begin
        drain();
        current = dir_rows[i].setting;
        load_setting(dir_settings[current]);
      end
      if (dir_rows[i].typed) begin
        typed_color = unpack_color(dir_rows[i].color);
        if (gradient_color('{dir_rows[i].x, dir_rows[i].y}) != typed_color) begin
          $display("%0t: directed row %0d, expected %h, predicted otherwise",
                   $time, i, dir_rows[i].color);
          fail_count++;
        end
      end
      send_pixel(dir_rows[i].x, dir_rows[i].y);
    end

    // Random part in three idling phases, several register settings each.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 24; recv_idle_pct = 79; end
        1: begin send_idle_pct = 79; recv_idle_pct = 24; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int s = 0; s < SETS; s++) begin
        drain();
        random_setting(s == 0);
        repeat (PER_SET) random_pixel();
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
